### rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    // Operation codes carried in the func field
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;
    localparam int WORD_W  = 32;

    typedef struct packed {
        logic                     func;
        logic [WORD_W-1:0]        item_value;
        logic signed [PRIO_W-1:0] priority_req;
    } t_cmd;

    typedef struct packed {
        logic                     front_valid;
        logic [WORD_W-1:0]        front_item;
        logic signed [PRIO_W-1:0] front_priority;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic                     dropped;
    } t_result;

    // Control broadcast to every cell in the same cycle
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [PRIO_W-1:0] prio;
    } t_cell_ctl;

    // Status a cell shows to its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     keep;
        logic signed [PRIO_W-1:0] prio;
    } t_tap;

endpackage

### rtl/spq_cell.sv
// One slot of the sorted shift chain: holds an entry and moves it left or right.
module spq_cell #(
    parameter int ITEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic [ITEM_WIDTH-1:0] i_new_item,
    input  spq_pkg::t_tap         i_left_tap,
    input  logic [ITEM_WIDTH-1:0] i_left_item,
    input  spq_pkg::t_tap         i_right_tap,
    input  logic [ITEM_WIDTH-1:0] i_right_item,
    output spq_pkg::t_tap         o_tap,
    output logic [ITEM_WIDTH-1:0] o_item
);

    logic                             r_valid, n_valid;
    logic signed [spq_pkg::PRIO_W-1:0] r_prio, n_prio;
    logic [ITEM_WIDTH-1:0]            r_item, n_item;
    logic                             w_keep;

    // Hold this entry when it is ahead of or equal to the new priority
    assign w_keep = r_valid && (r_prio <= i_ctl.prio);

    always_comb begin
        n_valid = r_valid;
        n_prio  = r_prio;
        n_item  = r_item;
        if (i_ctl.enq) begin
            if (!w_keep) begin
                if (i_left_tap.keep) begin
                    // insertion point: take the new entry
                    n_prio = i_ctl.prio;
                    n_item = i_new_item;
                end else begin
                    // behind the insertion point: advance from the left
                    n_prio = i_left_tap.prio;
                    n_item = i_left_item;
                end
                n_valid = r_valid || i_left_tap.valid;
            end
        end else if (i_ctl.deq) begin
            // pull the neighbor toward the front
            n_valid = i_right_tap.valid;
            n_prio  = i_right_tap.prio;
            n_item  = i_right_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_item <= n_item;
    end

    assign o_tap.valid = r_valid;
    assign o_tap.keep  = w_keep;
    assign o_tap.prio  = r_prio;
    assign o_item      = r_item;

endmodule

### rtl/sorted_priority_queue_top.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// Each start transaction is either an enqueue (item plus signed priority) or a
// dequeue of the front entry; the queue takes one transaction every clock, since
// every cell compares the new priority against its own entry in parallel and
// shifts in the same cycle. busy stays low. The result of a transaction appears
// with o_done in the following cycle for exactly one cycle and cannot be held
// off. Lowest priority value is at the front; equal priorities keep arrival
// order. An enqueue into a full queue is discarded and flagged with dropped; a
// dequeue from an empty queue changes nothing.
module sorted_priority_queue_top #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  spq_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output spq_pkg::t_result o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    spq_pkg::t_cell_ctl    w_ctl;
    spq_pkg::t_tap         w_tap       [DEPTH];
    spq_pkg::t_tap         w_left_tap  [DEPTH];
    spq_pkg::t_tap         w_right_tap [DEPTH];
    logic [ITEM_WIDTH-1:0] w_item      [DEPTH];
    logic [ITEM_WIDTH-1:0] w_left_item [DEPTH];
    logic [ITEM_WIDTH-1:0] w_right_item[DEPTH];
    logic [ITEM_WIDTH-1:0] w_new_item;
    logic [DEPTH-1:0]      w_valid;

    logic          r_count, n_count_unused;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, r_dropped;
    logic          w_accept, w_full, w_empty, w_is_enq, w_is_deq;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_cnt == CW'(DEPTH));
    assign w_empty  = (r_cnt == '0);
    assign w_is_enq = w_accept && (i_cmd.func == spq_pkg::FUNC_ENQ);
    assign w_is_deq = w_accept && (i_cmd.func == spq_pkg::FUNC_DEQ);

    // Broadcast the operation; drop full enqueues and empty dequeues
    assign w_ctl.enq  = w_is_enq && !w_full;
    assign w_ctl.deq  = w_is_deq && !w_empty;
    assign w_ctl.prio = i_cmd.priority_req;
    assign w_new_item = ITEM_WIDTH'(64'(i_cmd.item_value));

    // Wire each cell to its neighbors; the front sees a keeping, valid left side
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                w_left_tap[i]  = '{valid: 1'b1, keep: 1'b1, prio: '0};
                w_left_item[i] = '0;
            end else begin
                w_left_tap[i]  = w_tap[i-1];
                w_left_item[i] = w_item[i-1];
            end
            if (i == DEPTH - 1) begin
                w_right_tap[i]  = '{valid: 1'b0, keep: 1'b0, prio: '0};
                w_right_item[i] = '0;
            end else begin
                w_right_tap[i]  = w_tap[i+1];
                w_right_item[i] = w_item[i+1];
            end
            w_valid[i] = w_tap[i].valid;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            spq_cell #(
                .ITEM_WIDTH(ITEM_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_new_item  (w_new_item),
                .i_left_tap  (w_left_tap[g]),
                .i_left_item (w_left_item[g]),
                .i_right_tap (w_right_tap[g]),
                .i_right_item(w_right_item[g]),
                .o_tap       (w_tap[g]),
                .o_item      (w_item[g])
            );
        end
    endgenerate

    // Track the number of stored entries
    always_comb begin
        n_cnt = r_cnt;
        if (w_ctl.enq) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_ctl.deq) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    assign n_count_unused = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_done    <= 1'b0;
            r_dropped <= 1'b0;
            r_count   <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_done    <= w_accept;
            r_dropped <= w_is_enq && w_full;
            r_count   <= n_count_unused;
        end
    end

    // Report the front entry and status after the transaction
    assign o_done                  = r_done;
    assign o_result.front_valid    = w_tap[0].valid;
    assign o_result.front_item     = w_tap[0].valid ? 32'(64'(w_item[0])) : '0;
    assign o_result.front_priority = w_tap[0].valid ? w_tap[0].prio : '0;
    assign o_result.entry_count    = spq_pkg::COUNT_W'(64'(r_cnt));
    assign o_result.is_empty       = !w_tap[0].valid;
    assign o_result.dropped        = r_dropped && !r_count;

    // Front cell holds an entry exactly when the count is nonzero
    a_front_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) == w_valid[0])
        else $error("front valid disagrees with entry count");

    // Last cell holds an entry exactly when the queue is full
    a_last_matches_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[DEPTH-1] == w_full)
        else $error("last cell valid disagrees with full");

    // A refused enqueue leaves the count alone and flags the drop
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_is_enq && w_full) |=> ($stable(r_cnt) && r_dropped))
        else $error("enqueue into full queue not dropped");

    // A dequeue from a nonempty queue removes exactly one entry
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_is_deq && !w_empty) |=> (r_cnt == $past(r_cnt) - CW'(1)))
        else $error("dequeue did not remove one entry");

    // The number of valid cells matches the entry count
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_cnt))
        else $error("valid cells do not match entry count");

endmodule

### tb/testbench.sv
// Self-checking testbench for the sorted priority queue top level.
`timescale 1ns / 100ps

module testbench;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_ITEMS  = 500;
    localparam int DRAIN_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;

    // One row of the directed table; pinned rows carry a hand-written front status
    typedef struct {
        spq_pkg::t_cmd    cmd;
        bit               pinned;
        spq_pkg::t_result want;
    } t_stim_row;

    // Per-transaction note from the sender to the checker
    typedef struct {
        bit               pinned;
        spq_pkg::t_result want;
    } t_pin_note;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    spq_pkg::t_cmd    i_cmd   = '0;
    logic             busy;
    logic             o_done;
    spq_pkg::t_result o_result;

    // Shadow copy of the queue contents, front at slot 0
    logic [spq_pkg::WORD_W-1:0]        shadow_items [QUEUE_DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0] shadow_prios [QUEUE_DEPTH];
    int                                shadow_count = 0;

    spq_pkg::t_result expected_fronts[$];
    t_pin_note        pin_notes[$];
    t_stim_row        directed_rows[$];

    int  cmds_sent    = 0;
    int  fronts_seen  = 0;
    int  mismatches   = 0;
    bit  steady       = 1'b0;

    sorted_priority_queue_top #(
        .DEPTH      (QUEUE_DEPTH),
        .ITEM_WIDTH (32)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Free-running clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply one transaction to the shadow queue and return the front status after it
    function automatic spq_pkg::t_result predict_front(input spq_pkg::t_cmd c);
        spq_pkg::t_result                  r;
        int                                pos;
        int                                i;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        r    = '0;
        prio = $signed(c.priority_req);
        if (c.func == spq_pkg::FUNC_DEQ) begin
            if (shadow_count > 0) begin
                for (i = 0; i + 1 < shadow_count; i++) begin
                    shadow_items[i] = shadow_items[i + 1];
                    shadow_prios[i] = shadow_prios[i + 1];
                end
                shadow_count--;
            end
        end else if (shadow_count >= QUEUE_DEPTH) begin
            r.dropped = 1'b1;
        end else begin
            // Insert behind every entry with priority less than or equal
            pos = 0;
            while (pos < shadow_count && shadow_prios[pos] <= prio)
                pos++;
            for (i = shadow_count; i > pos; i--) begin
                shadow_items[i] = shadow_items[i - 1];
                shadow_prios[i] = shadow_prios[i - 1];
            end
            shadow_items[pos] = c.item_value;
            shadow_prios[pos] = prio;
            shadow_count++;
        end
        if (shadow_count > 0) begin
            r.front_valid    = 1'b1;
            r.front_item     = shadow_items[0];
            r.front_priority = shadow_prios[0];
        end else begin
            r.is_empty = 1'b1;
        end
        r.entry_count = shadow_count[spq_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic string fmt_front(input spq_pkg::t_result r);
        return $sformatf("valid=%0b item=%h prio=%0d count=%0d empty=%0b dropped=%0b",
                         r.front_valid, r.front_item, $signed(r.front_priority),
                         r.entry_count, r.is_empty, r.dropped);
    endfunction

    function automatic spq_pkg::t_cmd make_cmd(input logic func,
                                               input logic [spq_pkg::WORD_W-1:0] item,
                                               input logic signed [spq_pkg::PRIO_W-1:0] prio);
        spq_pkg::t_cmd c;
        c.func         = func;
        c.item_value   = item;
        c.priority_req = prio;
        return c;
    endfunction

    function automatic spq_pkg::t_result make_front(input logic valid,
                                                    input logic [spq_pkg::WORD_W-1:0] item,
                                                    input logic signed [spq_pkg::PRIO_W-1:0] prio,
                                                    input logic [spq_pkg::COUNT_W-1:0] count,
                                                    input logic empty, input logic drop);
        spq_pkg::t_result r;
        r.front_valid    = valid;
        r.front_item     = item;
        r.front_priority = prio;
        r.entry_count    = count;
        r.is_empty       = empty;
        r.dropped        = drop;
        return r;
    endfunction

    function automatic t_stim_row make_row(input spq_pkg::t_cmd c, input bit pinned,
                                           input spq_pkg::t_result w);
        t_stim_row row;
        row.cmd    = c;
        row.pinned = pinned;
        row.want   = w;
        return row;
    endfunction

    // Random transaction; enq_pct sets the share of enqueues
    function automatic spq_pkg::t_cmd random_cmd(input int enq_pct);
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        case ($urandom_range(0, 3))
            0:       prio = 16'($signed($urandom_range(0, 4)) - 2);
            1:       prio = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: prio = 16'($urandom);
        endcase
        return make_cmd(($urandom_range(0, 99) < enq_pct) ? spq_pkg::FUNC_ENQ
                                                          : spq_pkg::FUNC_DEQ,
                        $urandom, prio);
    endfunction

    // Present one transaction, hold it until accepted, then idle at random unless steady is set
    task automatic issue_cmd(input spq_pkg::t_cmd c, input bit pinned,
                             input spq_pkg::t_result w);
        t_pin_note note;
        int        gap;
        note.pinned = pinned;
        note.want   = w;
        pin_notes.push_back(note);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        cmds_sent++;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every outstanding front status
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        start <= 1'b0;
        while (fronts_seen < cmds_sent && cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (fronts_seen < cmds_sent) begin
            mismatches++;
            $display("ERROR: %0d transactions still without a result", cmds_sent - fronts_seen);
        end
    endtask

    // Check each result against the oldest expectation, then record new transactions
    always @(posedge i_clk) begin : check_fronts
        spq_pkg::t_result want;
        t_pin_note        note;
        if (i_rst_n) begin
            if (o_done) begin
                fronts_seen++;
                if (expected_fronts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result: %s", fmt_front(o_result));
                end else begin
                    want = expected_fronts.pop_front();
                    if (o_result.front_valid    !== want.front_valid    ||
                        o_result.front_item     !== want.front_item     ||
                        o_result.front_priority !== want.front_priority ||
                        o_result.entry_count    !== want.entry_count    ||
                        o_result.is_empty       !== want.is_empty       ||
                        o_result.dropped        !== want.dropped) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR: result mismatch at %0t", $realtime);
                            $display("  expected %s", fmt_front(want));
                            $display("  actual   %s", fmt_front(o_result));
                        end
                    end
                end
            end
            if (start && !busy) begin
                want = predict_front(i_cmd);
                note = pin_notes.pop_front();
                if (note.pinned)
                    want = note.want;
                expected_fronts.push_back(want);
            end
        end
    end

    // Main stimulus
    initial begin : stimulus
        spq_pkg::t_result none;
        spq_pkg::t_cmd    c;
        int               enq_pct;
        int               burst;
        int               random_sent;
        bit               paused;
        none        = '0;
        random_sent = 0;
        paused      = 1'b0;

        // Directed rows: empty dequeue, extremes, ties, fill to full, drops, dequeue from full
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_DEQ, 32'hFFFF_FFFF, 16'sh7FFF),
                                         1'b1,
                                         make_front(1'b0, '0, '0, 5'd0, 1'b1, 1'b0)));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 16'sh7FFF),
                                         1'b1,
                                         make_front(1'b1, 32'hFFFF_FFFF, 16'sh7FFF, 5'd1,
                                                    1'b0, 1'b0)));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h0000_0000, 16'sh8000),
                                         1'b1,
                                         make_front(1'b1, 32'h0, 16'sh8000, 5'd2, 1'b0, 1'b0)));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'hA5A5_A5A5, 16'sh0000),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h5A5A_5A5A, 16'sh0000),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h0000_0001, 16'sh7FFF),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h1111_1111, 16'shFFFF),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h2222_2222, 16'sh0001),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h3333_3333, 16'sh8001),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h4444_4444, 16'sh7FFE),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h5555_5555, 16'sh0064),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h6666_6666, 16'shFF9C),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h7777_7777, 16'sh0000),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h8888_8888, 16'sh1234),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h9999_9999, 16'shEDCC),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'hBBBB_BBBB, 16'sh4000),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'h8000_0000, 16'sh8000),
                                         1'b0, none));
        // Queue is full: both of these are refused
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'hDEAD_BEEF, 16'sh8000),
                                         1'b1,
                                         make_front(1'b1, 32'h0, 16'sh8000, 5'd16, 1'b0, 1'b1)));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 16'sh7FFF),
                                         1'b1,
                                         make_front(1'b1, 32'h0, 16'sh8000, 5'd16, 1'b0, 1'b1)));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_DEQ, 32'h0, 16'sh0),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_DEQ, 32'hFFFF_FFFF, 16'shFFFF),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_DEQ, 32'h0, 16'sh0),
                                         1'b0, none));
        directed_rows.push_back(make_row(make_cmd(spq_pkg::FUNC_ENQ, 32'hC0DE_0001, 16'sh0000),
                                         1'b0, none));

        // Hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            issue_cmd(directed_rows[k].cmd, directed_rows[k].pinned, directed_rows[k].want);

        // Random bursts that lean toward filling, mixing or draining the queue
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 15;
            endcase
            steady = ($urandom_range(0, 3) == 0);
            burst  = $urandom_range(10, 40);
            repeat (burst) begin
                c = random_cmd(enq_pct);
                issue_cmd(c, 1'b0, none);
                random_sent++;
            end
            // Let the queue go quiet once mid-run
            if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                @(posedge i_clk);
                paused = 1'b1;
            end
        end

        // Drain and settle, then report
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_fronts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #600000;
        $display("Some tests failed");
        $finish;
    end

endmodule
